// ----- sv/ctt_pkg.sv -----
package ctt_pkg;

  // Longest word or quoted string, in bytes, and the width of a length count
  localparam int MAX_TOKEN_LEN = 1024;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);

  // Result queue depth and its pointer and count widths
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Characters of interest
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UX     = 8'h58;

  typedef enum logic [2:0] {
    K_SEMI, K_OPEN, K_CLOSE, K_STRING, K_WORD, K_END, K_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE, E_OPEN_QUOTE, E_TOO_LONG
  } err_t;

  typedef enum logic [1:0] {
    C_TEXT, C_UNSIGNED, C_NEGATIVE, C_BOOL
  } class_t;

  typedef enum logic [2:0] {
    M_IDLE, M_WORD, M_STRING, M_COMMENT, M_HALT
  } mode_t;

  typedef enum logic [2:0] {
    P_START, P_SIGN, P_ZERO, P_DEC, P_ZX, P_HEX, P_BAD
  } phase_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t             token_kind;
    err_t              error_code;
    class_t            word_class;
    logic [31:0]       number;
    logic [31:0]       token_offset;
    logic [LEN_W-1:0]  token_length;
    logic [31:0]       line_number;
    logic              last_in_run;
  } out_item_t;

  // Running state of the current word or string
  typedef struct packed {
    logic [LEN_W-1:0] run_length;
    logic [31:0]      dec_value;
    logic [31:0]      hex_value;
    phase_t           phase;
    logic             neg;
    logic [1:0]       bool_match;  // bit 0: still "true", bit 1: still "false"
  } word_t;

  localparam word_t WORD_RESET = '{
    run_length: '0, dec_value: '0, hex_value: '0,
    phase: P_START, neg: 1'b0, bool_match: 2'b11
  };

  // Results of one scanned item toward the queue
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } scan_out_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b inside {[8'd9:8'd13]});
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    return is_space(b) || (b inside {CH_SEMI, CH_HASH, CH_QUOTE, CH_OPEN, CH_CLOSE});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[CH_ZERO:CH_NINE]};
  endfunction

  // Hex digit value with a valid flag in the top bit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b inside {[CH_ZERO:CH_NINE]}) r = {1'b1, b[3:0]};
    else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return (b inside {[8'h61:8'h7A]}) ? (b - 8'd32) : b;
  endfunction

  function automatic logic [7:0] true_char(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      2'd0:    c = 8'h54;
      2'd1:    c = 8'h52;
      2'd2:    c = 8'h55;
      default: c = 8'h45;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] false_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h4C;
      3'd3:    c = 8'h53;
      3'd4:    c = 8'h45;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

  // Fold one byte into the word state
  function automatic word_t word_byte(input word_t w, input logic [7:0] b);
    word_t      n;
    logic [7:0] ub;
    logic [4:0] hd;
    logic       dg;
    n  = w;
    ub = to_upper(b);
    hd = hex_digit(b);
    dg = is_digit(b);
    if (w.run_length >= LEN_W'(4) || ub != true_char(w.run_length[1:0]))
      n.bool_match[0] = 1'b0;
    if (w.run_length >= LEN_W'(5) || ub != false_char(w.run_length[2:0]))
      n.bool_match[1] = 1'b0;
    case (w.phase)
      P_START, P_SIGN: begin
        if (w.phase == P_START && b == CH_PLUS) n.phase = P_SIGN;
        else if (w.phase == P_START && b == CH_MINUS) begin
          n.phase = P_SIGN;
          n.neg   = 1'b1;
        end else if (b == CH_ZERO) n.phase = P_ZERO;
        else if (dg) begin
          n.phase     = P_DEC;
          n.dec_value = {28'd0, b[3:0]};
        end else n.phase = P_BAD;
      end
      P_ZERO: begin
        if (b == CH_LX || b == CH_UX) n.phase = P_ZX;
        else if (dg) begin
          n.phase     = P_DEC;
          n.dec_value = {28'd0, b[3:0]};
        end else n.phase = P_BAD;
      end
      P_DEC: begin
        if (dg) n.dec_value = (w.dec_value << 3) + (w.dec_value << 1) + {28'd0, b[3:0]};
        else n.phase = P_BAD;
      end
      P_ZX, P_HEX: begin
        if (hd[4]) begin
          n.hex_value = ((w.phase == P_ZX) ? 32'd0 : {w.hex_value[27:0], 4'd0})
                        | {28'd0, hd[3:0]};
          n.phase = P_HEX;
        end else n.phase = P_BAD;
      end
      default: n.phase = P_BAD;
    endcase
    n.run_length = w.run_length + LEN_W'(1);
    return n;
  endfunction

  function automatic out_item_t make_token(input kind_t kind, input err_t err,
                                           input logic [31:0] off,
                                           input logic [LEN_W-1:0] len,
                                           input logic [31:0] line);
    out_item_t r;
    r              = '0;
    r.token_kind   = kind;
    r.error_code   = err;
    r.word_class   = C_TEXT;
    r.token_offset = off;
    r.token_length = len;
    r.line_number  = line;
    return r;
  endfunction

  // Classify a finished word
  function automatic out_item_t word_result(input word_t w, input logic [31:0] off,
                                            input logic [31:0] line);
    out_item_t   r;
    logic [31:0] mag;
    r   = make_token(K_WORD, E_NONE, off, w.run_length, line);
    mag = (w.phase == P_HEX) ? w.hex_value : w.dec_value;
    if (w.phase inside {P_ZERO, P_DEC, P_HEX}) begin
      if (w.neg) begin
        r.word_class = C_NEGATIVE;
        r.number     = 32'd0 - mag;
      end else begin
        r.word_class = C_UNSIGNED;
        r.number     = mag;
      end
    end else if (w.run_length == LEN_W'(4) && w.bool_match[0]) begin
      r.word_class = C_BOOL;
      r.number     = 32'd1;
    end else if (w.run_length == LEN_W'(5) && w.bool_match[1]) begin
      r.word_class = C_BOOL;
      r.number     = 32'd0;
    end
    return r;
  endfunction

endpackage

// ----- sv/ctt_scan.sv -----
module ctt_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  ctt_pkg::in_item_t   item,
  input  logic                adv,
  output ctt_pkg::scan_out_t  res
);
  import ctt_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic        esc_r, esc_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] line_r, line_nxt;
  logic [31:0] start_pos_r, start_pos_nxt;
  logic [31:0] start_line_r, start_line_nxt;
  word_t       word_r, word_nxt;

  word_t       word_fold;
  logic [7:0]  b;

  assign b = item.data_byte;

  // One word-byte step, from a fresh word unless one is in progress
  assign word_fold = word_byte((mode_r == M_WORD) ? word_r : WORD_RESET, b);

  // Scan one byte or the end command
  always_comb begin
    logic      fresh;
    logic      tok_en;
    out_item_t tok;
    res            = '0;
    mode_nxt       = mode_r;
    esc_nxt        = esc_r;
    pos_nxt        = pos_r;
    line_nxt       = line_r;
    start_pos_nxt  = start_pos_r;
    start_line_nxt = start_line_r;
    word_nxt       = word_r;
    fresh          = 1'b0;
    tok_en         = 1'b0;
    tok            = make_token(K_SEMI, E_NONE, pos_r, LEN_W'(1), line_r);

    if (item.cmd) begin
      // Flush, mark end, return to reset state
      if (mode_r == M_WORD) begin
        res.first = word_result(word_r, start_pos_r, start_line_r);
        res.count = 2'd1;
      end else if (mode_r == M_STRING) begin
        res.first = make_token(K_ERROR, E_OPEN_QUOTE, start_pos_r, word_r.run_length,
                               start_line_r);
        res.count = 2'd1;
      end
      tok    = make_token(K_END, E_NONE, pos_r, '0, line_r);
      tok_en = 1'b1;
      mode_nxt       = M_IDLE;
      esc_nxt        = 1'b0;
      pos_nxt        = '0;
      line_nxt       = 32'd1;
      start_pos_nxt  = '0;
      start_line_nxt = 32'd1;
      word_nxt       = WORD_RESET;
    end else begin
      case (mode_r)
        M_IDLE: fresh = 1'b1;
        M_COMMENT: begin
          if (b == CH_NL) mode_nxt = M_IDLE;
        end
        M_STRING: begin
          if (word_r.run_length >= LEN_W'(MAX_TOKEN_LEN)) begin
            res.first = make_token(K_ERROR, E_TOO_LONG, start_pos_r, word_r.run_length,
                                   start_line_r);
            res.count = 2'd1;
            mode_nxt  = M_HALT;
          end else begin
            word_nxt.run_length = word_r.run_length + LEN_W'(1);
            esc_nxt = 1'b0;
            if (!(esc_r && b == CH_QUOTE)) begin
              if (b == CH_QUOTE) begin
                res.first = make_token(K_STRING, E_NONE, start_pos_r,
                                       word_r.run_length + LEN_W'(1), start_line_r);
                res.count = 2'd1;
                mode_nxt  = M_IDLE;
              end else if (b == CH_BSLASH) begin
                esc_nxt = 1'b1;
              end
            end
          end
        end
        M_WORD: begin
          if (is_delim(b)) begin
            res.first = word_result(word_r, start_pos_r, start_line_r);
            res.count = 2'd1;
            mode_nxt  = M_IDLE;
            fresh     = 1'b1;
          end else if (word_r.run_length >= LEN_W'(MAX_TOKEN_LEN)) begin
            res.first = make_token(K_ERROR, E_TOO_LONG, start_pos_r, word_r.run_length,
                                   start_line_r);
            res.count = 2'd1;
            mode_nxt  = M_HALT;
          end else begin
            word_nxt = word_fold;
          end
        end
        default: ;
      endcase

      // Start a new token from idle, or right after a word ends on a delimiter
      if (fresh) begin
        case (b)
          CH_SEMI: tok_en = 1'b1;
          CH_OPEN: begin
            tok.token_kind = K_OPEN;
            tok_en         = 1'b1;
          end
          CH_CLOSE: begin
            tok.token_kind = K_CLOSE;
            tok_en         = 1'b1;
          end
          CH_HASH: mode_nxt = M_COMMENT;
          CH_QUOTE: begin
            start_pos_nxt       = pos_r;
            start_line_nxt      = line_r;
            word_nxt            = WORD_RESET;
            word_nxt.run_length = LEN_W'(1);
            esc_nxt             = 1'b0;
            mode_nxt            = M_STRING;
          end
          default: begin
            if (!is_space(b)) begin
              start_pos_nxt  = pos_r;
              start_line_nxt = line_r;
              word_nxt       = word_fold;
              mode_nxt       = M_WORD;
            end
          end
        endcase
      end

      if (b == CH_NL) line_nxt = line_r + 32'd1;
      pos_nxt = pos_r + 32'd1;
    end

    // Place the single-byte or end token after any earlier result
    if (tok_en) begin
      if (res.count == 2'd0) begin
        res.first = tok;
        res.count = 2'd1;
      end else begin
        res.second = tok;
        res.count  = 2'd2;
      end
    end

    // Mark the last result of this word
    if (res.count == 2'd1) res.first.last_in_run = 1'b1;
    if (res.count == 2'd2) res.second.last_in_run = 1'b1;
  end

  // Hold scanner state, advance on each scanned item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      esc_r        <= 1'b0;
      pos_r        <= '0;
      line_r       <= 32'd1;
      start_pos_r  <= '0;
      start_line_r <= 32'd1;
      word_r       <= WORD_RESET;
    end else if (adv) begin
      mode_r       <= mode_nxt;
      esc_r        <= esc_nxt;
      pos_r        <= pos_nxt;
      line_r       <= line_nxt;
      start_pos_r  <= start_pos_nxt;
      start_line_r <= start_line_nxt;
      word_r       <= word_nxt;
    end
  end

endmodule

// ----- sv/ctt_oq.sv -----
module ctt_oq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_en,
  input  ctt_pkg::scan_out_t  push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output ctt_pkg::out_item_t  out_data
);
  import ctt_pkg::*;

  out_item_t             mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wp_r, wp_nxt;
  logic [OQ_PTR_W-1:0]   rp_r, rp_nxt;
  logic [OQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [OQ_CNT_W-1:0]   n_push;
  logic                  pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign n_push    = push_en ? OQ_CNT_W'(push.count) : '0;

  assign wp_nxt  = wp_r + OQ_PTR_W'(n_push);
  assign rp_nxt  = rp_r + OQ_PTR_W'(pop);
  assign cnt_nxt = cnt_r + n_push - OQ_CNT_W'(pop);

  // Store up to two results per cycle
  always_ff @(posedge clk) begin
    if (push_en && push.count != 2'd0) mem_r[wp_r] <= push.first;
    if (push_en && push.count == 2'd2) mem_r[wp_r + OQ_PTR_W'(1)] <= push.second;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- sv/config_text_tokenizer.sv -----
// Configuration text tokenizer: takes one byte (or the end command) per word on the
// input channel and emits semicolon, brace, quoted-string, word, end and error tokens,
// each with offset, length and start line; words are classed as text, unsigned,
// negative integer or boolean with their value. One input word is taken every cycle
// while input is not stalled: it is held in an input register, scanned once the
// result queue has room, and its zero, one or two results are written into a
// four-entry result queue. Input stalls only while that queue holds more than two
// results; since the result port moves at most one token a cycle, a steady stream of
// bytes that each end a word and give two tokens is held back by the result port.
module config_text_tokenizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ctt_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ctt_pkg::out_item_t  out_data
);
  import ctt_pkg::*;

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      room;
  logic      adv;
  scan_out_t scan_res;

  assign in_ready = !in_vld_r || room;
  assign adv      = in_vld_r && room;

  // Hold the accepted word until the scanner takes it
  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else if (in_ready) in_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_item_r <= in_data;
  end

  ctt_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (in_item_r),
    .adv   (adv),
    .res   (scan_res)
  );

  ctt_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (adv),
    .push      (scan_res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
